@@ hdl/brd_pkg.sv @@
// ----------------------------------------------------------------------------
// brd_pkg
// Section codes, status codes and header layout constants shared by the
// BAM record deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package brd_pkg;

    localparam int HEADER_BYTES = 36;

    localparam logic [5:0]  HDR_LAST     = 6'(HEADER_BYTES - 1);
    localparam logic [31:0] HDR_BODY_OFS = 32'(HEADER_BYTES - 4);

    localparam logic [5:0] HDR_NAME_LEN  = 6'd12;
    localparam logic [5:0] HDR_CIGAR_LO  = 6'd16;
    localparam logic [5:0] HDR_CIGAR_END = 6'd18;
    localparam logic [5:0] HDR_SEQ_LO    = 6'd20;
    localparam logic [5:0] HDR_SEQ_END   = 6'd24;
    localparam logic [5:0] HDR_BLK_END   = 6'd4;

    localparam logic [2:0] SEC_HEADER = 3'd0;
    localparam logic [2:0] SEC_NAME   = 3'd1;
    localparam logic [2:0] SEC_TERM   = 3'd2;
    localparam logic [2:0] SEC_CIGAR  = 3'd3;
    localparam logic [2:0] SEC_SEQ    = 3'd4;
    localparam logic [2:0] SEC_QUAL   = 3'd5;
    localparam logic [2:0] SEC_TAGS   = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;

    localparam int TDATA_W = 80;
    localparam int TUSER_W = 3;

endpackage

`default_nettype wire

@@ hdl/bam_record_deframer.sv @@
// ----------------------------------------------------------------------------
// bam_record_deframer
// Labels a raw BAM alignment record byte stream with section, offset,
// record index and status, one byte per item.
// ----------------------------------------------------------------------------
// One byte is accepted in every cycle in which the output register is empty
// or is being drained; the labelled item appears on the master side in the
// cycle after acceptance. The header fields are captured and the section
// counters stepped in the same cycle the byte is accepted, so throughput is
// one item per clock, with no per-record bubbles, while m_tready holds high.
`default_nettype none

module bam_record_deframer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // [7:0] data_byte
    input  wire logic                         s_tlast,  // end_of_buffer
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [7:0] byte_out, [39:8] section_offset, [71:40] record_number,
    // [73:72] status, [79:74] zero
    output logic [brd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [brd_pkg::TUSER_W-1:0]       m_tuser,  // [2:0] section
    output logic                              m_tlast   // record_end
);
    import brd_pkg::*;

    logic [5:0]  hc_reg, hc_next;
    logic [31:0] blk_reg, blk_next;
    logic [7:0]  name_reg, name_next;
    logic [15:0] cig_reg, cig_next;
    logic [31:0] seq_reg, seq_next;
    logic [2:0]  sec_reg, sec_next;
    logic [31:0] sr_reg, sr_next;
    logic [31:0] rr_reg, rr_next;
    logic [31:0] ofs_reg, ofs_next;
    logic [31:0] rec_reg, rec_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [2:0]  out_sec_reg;
    logic [31:0] out_ofs_reg;
    logic        out_end_reg;
    logic [31:0] out_rec_reg;
    logic [1:0]  out_st_reg;

    logic        s_fire;
    logic        in_header;
    logic [2:0]  res_sec;
    logic [31:0] res_ofs;
    logic        res_end;
    logic [1:0]  res_st;
    logic [31:0] rr_dec;
    logic [31:0] sr_dec;
    logic [31:0] seq_half;
    logic        name_nz, cig_nz, seq_nz;
    logic [2:0]  adv_sec;
    logic [31:0] adv_len;
    logic        do_adv;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign in_header = (sec_reg == SEC_HEADER) || (sec_reg > SEC_TAGS);

    always_comb begin
        hc_next   = hc_reg;
        blk_next  = blk_reg;
        name_next = name_reg;
        cig_next  = cig_reg;
        seq_next  = seq_reg;
        sec_next  = sec_reg;
        sr_next   = sr_reg;
        rr_next   = rr_reg;
        ofs_next  = ofs_reg;
        rec_next  = rec_reg;
        res_sec   = sec_reg;
        res_ofs   = ofs_reg;
        res_end   = 1'b0;
        res_st    = ST_OK;
        rr_dec    = (rr_reg != 32'd0) ? rr_reg - 32'd1 : 32'd0;
        sr_dec    = (sr_reg != 32'd0) ? sr_reg - 32'd1 : 32'd0;
        do_adv    = 1'b0;

        if (in_header) begin
            res_sec = SEC_HEADER;
            res_ofs = {26'd0, hc_reg};
            if (hc_reg == 6'd0) begin
                blk_next  = 32'd0;
                name_next = 8'd0;
                cig_next  = 16'd0;
                seq_next  = 32'd0;
            end
            if (hc_reg < HDR_BLK_END) begin
                blk_next = blk_next | ({24'd0, s_tdata} << {hc_reg[1:0], 3'd0});
            end else if (hc_reg == HDR_NAME_LEN) begin
                name_next = s_tdata;
            end else if (hc_reg >= HDR_CIGAR_LO && hc_reg < HDR_CIGAR_END) begin
                cig_next = cig_next | ({8'd0, s_tdata} << {hc_reg[0], 3'd0});
            end else if (hc_reg >= HDR_SEQ_LO && hc_reg < HDR_SEQ_END) begin
                seq_next = seq_next | ({24'd0, s_tdata} << {hc_reg[1:0], 3'd0});
            end
            hc_next = hc_reg + 6'd1;
            if (hc_reg >= HDR_LAST) begin
                hc_next = 6'd0;
                rr_next = (blk_next >= HDR_BODY_OFS) ? blk_next - HDR_BODY_OFS : 32'd0;
                do_adv  = 1'b1;
                if (rr_next == 32'd0) begin
                    res_end = 1'b1;
                    res_st  = ST_OVERRUN;
                end
            end
        end else begin
            rr_next = rr_dec;
            if (sec_reg < SEC_TAGS) begin
                sr_next = sr_dec;
                if (sr_dec == 32'd0) begin
                    do_adv = 1'b1;
                end else begin
                    ofs_next = ofs_reg + 32'd1;
                end
            end else begin
                ofs_next = ofs_reg + 32'd1;
            end
        end

        // pick the next non-empty section
        name_nz  = name_next > 8'd1;
        cig_nz   = cig_next != 16'd0;
        seq_nz   = seq_next != 32'd0;
        seq_half = {1'b0, seq_next[31:1]} + {31'd0, seq_next[0]};
        adv_sec  = SEC_TAGS;
        case (res_sec)
            SEC_HEADER: adv_sec = name_nz ? SEC_NAME : SEC_TERM;
            SEC_NAME:   adv_sec = SEC_TERM;
            SEC_TERM:   adv_sec = cig_nz ? SEC_CIGAR : (seq_nz ? SEC_SEQ : SEC_TAGS);
            SEC_CIGAR:  adv_sec = seq_nz ? SEC_SEQ : SEC_TAGS;
            SEC_SEQ:    adv_sec = SEC_QUAL;
            default:    adv_sec = SEC_TAGS;
        endcase
        case (adv_sec)
            SEC_NAME:  adv_len = {24'd0, name_next - 8'd1};
            SEC_TERM:  adv_len = 32'd1;
            SEC_CIGAR: adv_len = {14'd0, cig_next, 2'd0};
            SEC_SEQ:   adv_len = seq_half;
            SEC_QUAL:  adv_len = seq_next;
            default:   adv_len = 32'd0;
        endcase
        if (do_adv) begin
            sec_next = adv_sec;
            sr_next  = adv_len;
            ofs_next = 32'd0;
        end

        if (!in_header && rr_dec == 32'd0) begin
            res_end = 1'b1;
            res_st  = (sec_next < SEC_TAGS) ? ST_OVERRUN : ST_OK;
        end

        if (res_end || s_tlast) begin
            if (!res_end) begin
                res_st = ST_TRUNC;
            end
            hc_next  = 6'd0;
            sec_next = SEC_HEADER;
            sr_next  = 32'd0;
            rr_next  = 32'd0;
            ofs_next = 32'd0;
            rec_next = rec_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg   <= 6'd0;
            blk_reg  <= 32'd0;
            name_reg <= 8'd0;
            cig_reg  <= 16'd0;
            seq_reg  <= 32'd0;
            sec_reg  <= SEC_HEADER;
            sr_reg   <= 32'd0;
            rr_reg   <= 32'd0;
            ofs_reg  <= 32'd0;
            rec_reg  <= 32'd0;
        end else if (s_fire) begin
            hc_reg   <= hc_next;
            blk_reg  <= blk_next;
            name_reg <= name_next;
            cig_reg  <= cig_next;
            seq_reg  <= seq_next;
            sec_reg  <= sec_next;
            sr_reg   <= sr_next;
            rr_reg   <= rr_next;
            ofs_reg  <= ofs_next;
            rec_reg  <= rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_byte_reg <= s_tdata;
            out_sec_reg  <= res_sec;
            out_ofs_reg  <= res_ofs;
            out_end_reg  <= res_end;
            out_rec_reg  <= rec_reg;
            out_st_reg   <= res_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_st_reg, out_rec_reg, out_ofs_reg, out_byte_reg};
    assign m_tuser  = out_sec_reg;
    assign m_tlast  = out_end_reg;

    a_end_not_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[73:72] != ST_TRUNC)
        else $error("record end carries truncated status");

    a_overrun_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[73:72] == ST_OVERRUN |-> m_tlast)
        else $error("overrun status without record end");

    a_hc_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        hc_reg != 6'd0 |-> sec_reg == SEC_HEADER)
        else $error("header count running outside header");

    a_body_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg >= SEC_NAME && sec_reg <= SEC_TAGS |-> rr_reg != 32'd0)
        else $error("body section with no record bytes left");

    a_rec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !res_end && !s_tlast |=> $stable(rec_reg))
        else $error("record index moved inside a record");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bam_record_deframer. Drives raw BAM record byte
// streams and predicts each labelled item in a scoreboard. The streams are
// well-formed records, records whose block size runs short or long, records
// cut by the buffer end, and random noise. A queue of predicted labels is
// compared field by field against the master side. Source gaps and sink
// stalls are random and change from phase to phase; the last phase has none.
// ----------------------------------------------------------------------------
module testbench;
    import brd_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [7:0]  data;
        logic [2:0]  sec;
        logic [31:0] offset;
        logic        last;
        logic [31:0] recno;
        logic [1:0]  status;
    } byte_label_t;

    class bam_label_tracker;
        logic [5:0]  hdr_cnt;
        logic [31:0] blk_len;
        logic [7:0]  name_len;
        logic [15:0] cigar_ops;
        logic [31:0] seq_len;
        logic [2:0]  cur_sec;
        logic [31:0] sec_left;
        logic [31:0] rec_left;
        logic [31:0] ofs_cnt;
        logic [31:0] rec_cnt;
        byte_label_t expected_labels[$];
        int errors;
        int checked;
        int ok_records;
        int overrun_records;
        int cut_records;

        function new();
            restart_record();
            blk_len = '0;
            name_len = '0;
            cigar_ops = '0;
            seq_len = '0;
            rec_cnt = '0;
            errors = 0;
            checked = 0;
            ok_records = 0;
            overrun_records = 0;
            cut_records = 0;
        endfunction

        function void restart_record();
            hdr_cnt = '0;
            cur_sec = SEC_HEADER;
            sec_left = '0;
            rec_left = '0;
            ofs_cnt = '0;
        endfunction

        function logic [31:0] span_of(logic [2:0] s);
            case (s)
                SEC_NAME:  return (name_len != 0) ? 32'(name_len) - 32'd1 : 32'd0;
                SEC_TERM:  return 32'd1;
                SEC_CIGAR: return 32'(cigar_ops) << 2;
                SEC_SEQ:   return 32'((33'(seq_len) + 33'd1) >> 1);
                SEC_QUAL:  return seq_len;
                default:   return 32'd0;
            endcase
        endfunction

        // skip empty sections; tags when nothing else is left
        function void enter_after(logic [2:0] s);
            logic [2:0] n;
            n = s + 3'd1;
            while (n < SEC_TAGS && span_of(n) == 0)
                n = n + 3'd1;
            cur_sec = n;
            sec_left = (n < SEC_TAGS) ? span_of(n) : 32'd0;
            ofs_cnt = '0;
        endfunction

        function void note_byte(logic [7:0] b, logic eob);
            byte_label_t e;
            int idx;
            logic closes;
            logic [1:0] st;
            e.data = b;
            e.recno = rec_cnt;
            closes = 1'b0;
            st = ST_OK;
            if (cur_sec == SEC_HEADER || cur_sec > SEC_TAGS) begin
                idx = int'(hdr_cnt);
                e.sec = SEC_HEADER;
                e.offset = 32'(idx);
                if (idx == 0) begin
                    blk_len = '0;
                    name_len = '0;
                    cigar_ops = '0;
                    seq_len = '0;
                end
                if (idx < 4)
                    blk_len[idx*8 +: 8] = b;
                else if (idx == 12)
                    name_len = b;
                else if (idx >= 16 && idx < 18)
                    cigar_ops[(idx-16)*8 +: 8] = b;
                else if (idx >= 20 && idx < 24)
                    seq_len[(idx-20)*8 +: 8] = b;
                hdr_cnt = 6'(idx + 1);
                if (idx + 1 >= HEADER_BYTES) begin
                    hdr_cnt = '0;
                    rec_left = (blk_len >= 32'(HEADER_BYTES - 4))
                        ? blk_len - 32'(HEADER_BYTES - 4) : 32'd0;
                    enter_after(SEC_HEADER);
                    if (rec_left == 0) begin
                        closes = 1'b1;
                        st = ST_OVERRUN;
                    end
                end
            end else begin
                e.sec = cur_sec;
                e.offset = ofs_cnt;
                if (rec_left > 0)
                    rec_left = rec_left - 32'd1;
                if (cur_sec < SEC_TAGS) begin
                    if (sec_left > 0)
                        sec_left = sec_left - 32'd1;
                    if (sec_left == 0)
                        enter_after(e.sec);
                    else
                        ofs_cnt = ofs_cnt + 32'd1;
                end else begin
                    ofs_cnt = ofs_cnt + 32'd1;
                end
                if (rec_left == 0) begin
                    closes = 1'b1;
                    st = (cur_sec < SEC_TAGS) ? ST_OVERRUN : ST_OK;
                end
            end
            if (closes) begin
                if (st == ST_OK)
                    ok_records++;
                else
                    overrun_records++;
                restart_record();
                rec_cnt = rec_cnt + 32'd1;
            end else if (eob) begin
                st = ST_TRUNC;
                cut_records++;
                restart_record();
                rec_cnt = rec_cnt + 32'd1;
            end
            e.last = closes;
            e.status = st;
            expected_labels.push_back(e);
        endfunction

        function void flag_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_label(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser,
                                  logic tlast);
            byte_label_t e;
            if (expected_labels.size() == 0) begin
                $display("%0t unexpected item: expected none actual tdata %0h tuser %0h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            e = expected_labels.pop_front();
            checked++;
            flag_field("byte_out", 32'(e.data), 32'(tdata[7:0]));
            flag_field("section", 32'(e.sec), 32'(tuser[2:0]));
            flag_field("section_offset", e.offset, tdata[39:8]);
            flag_field("record_end", 32'(e.last), 32'(tlast));
            flag_field("record_number", e.recno, tdata[71:40]);
            flag_field("status", 32'(e.status), 32'(tdata[73:72]));
        endfunction

        function int outstanding();
            return expected_labels.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [TUSER_W-1:0]  m_tuser;
    logic                m_tlast;

    bam_label_tracker tracker;
    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    bam_record_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_label(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eob;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // cut: byte index that carries end_of_buffer and stops the record, -1 for none
    task automatic send_record(input logic [31:0] blk, input logic [7:0] lname,
                               input logic [15:0] ncig, input logic [31:0] lseq,
                               input int cut, input bit eob_at_end);
        longint total;
        logic [7:0] b;
        logic eob;
        total = (blk >= 32'(HEADER_BYTES - 4)) ? longint'(blk) + 4 : longint'(HEADER_BYTES);
        for (longint k = 0; k < total; k++) begin
            case (k)
                0, 1, 2, 3: b = blk[k*8 +: 8];
                12:         b = lname;
                16, 17:     b = ncig[(k-16)*8 +: 8];
                20, 21, 22, 23: b = lseq[(k-20)*8 +: 8];
                default:    b = 8'($urandom());
            endcase
            eob = (k == cut) || (eob_at_end && k == total - 1);
            send_item(b, eob);
            if (k == cut)
                break;
        end
    endtask

    task automatic random_record();
        int kind;
        int cut;
        logic [7:0] lname;
        logic [15:0] ncig;
        logic [31:0] lseq;
        logic [31:0] body;
        logic [31:0] blk;
        kind = $urandom_range(99);
        lname = 8'($urandom_range(0, 12));
        ncig = 16'($urandom_range(0, 4));
        lseq = $urandom_range(0, 24);
        body = ((lname == 0) ? 32'd1 : 32'(lname)) + 32'(ncig) * 4 + (lseq + 1) / 2 + lseq
             + $urandom_range(0, 16);
        blk = 32 + body;
        cut = -1;
        if (kind >= 90) begin
            blk = $urandom();
            lname = 8'($urandom());
            ncig = 16'($urandom());
            lseq = $urandom();
            cut = $urandom_range(0, 60);
        end else if (kind >= 80) begin
            cut = $urandom_range(0, blk + 3);
        end else if (kind >= 70) begin
            blk = $urandom_range(0, blk - 1);
        end
        send_record(blk, lname, ncig, lseq, cut, $urandom_range(7) == 0);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0)
            @(posedge aclk);
    endtask

    initial begin
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        src_gap_pct = 19;
        sink_stall_pct = 64;
        send_record(32'd0, 8'd5, 16'd1, 32'd3, -1, 1'b1);
        send_record(32'd32, 8'd2, 16'd0, 32'd0, -1, 1'b0);
        send_record(32'd44, 8'd0, 16'd1, 32'd3, -1, 1'b0);
        send_record(32'd52, 8'd4, 16'd2, 32'd5, -1, 1'b1);
        send_record(32'd41, 8'd3, 16'd1, 32'd6, -1, 1'b0);
        send_record(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 39, 1'b0);
        send_record(32'd48, 8'd4, 16'd1, 32'd2, 10, 1'b0);
        send_record(32'd37, 8'd1, 16'd0, 32'd1, -1, 1'b0);
        send_record(32'd60, 8'd2, 16'd0, 32'd4, -1, 1'b0);
        send_record(32'd40, 8'd9, 16'd3, 32'd8, -1, 1'b0);
        while (items_sent < 550)
            random_record();

        hold_until_drained();
        src_gap_pct = 64;
        sink_stall_pct = 19;
        while (items_sent < 1100)
            random_record();

        src_gap_pct = 0;
        sink_stall_pct = 0;
        while (items_sent < 1650)
            random_record();

        hold_until_drained();
        repeat (8) @(posedge aclk);

        $display("sent %0d bytes, checked %0d labelled items", items_sent, tracker.checked);
        $display("records: %0d complete, %0d overrun, %0d cut by buffer end",
                 tracker.ok_records, tracker.overrun_records, tracker.cut_records);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
